/* hw/rtl/gcd_pkg.sv */
// gcd_pkg: shared widths, fixed-point constants and helper functions for the
// great-circle distance unit (cordic arctangent table, q30 product)
// no dependencies
package gcd_pkg;

    localparam int CORDIC_STEPS_DEF = 32;

    // cordic datapath width and width of q30 operands between stages
    localparam int CW = 40;
    localparam int MW = 34;

    localparam logic signed [MW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [MW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [MW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [63:0]          QTR_PI_Q62  = 64'h3243F6A8885A308D;

    localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
    localparam logic signed [33:0] DLON_HALF = 34'sd1800000000;
    localparam logic signed [33:0] DLON_FULL = 34'sd3600000000;
    localparam logic [22:0]        RADIUS_M  = 23'd6371009;
    localparam logic [36:0]        MAX_MM    = 37'd20015115000;

    // atan(2^-i) in q30, from the arctangent series in q62, rounded half up
    function automatic logic [63:0] atan_q30(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        int          k;
        acc = 64'd0;
        if (i == 0) begin
            acc = QTR_PI_Q62;
        end else begin
            for (k = 0; k < 32; k++) begin
                sh = i * (2 * k + 1);
                if (sh <= 62) begin
                    term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
                    if (k[0]) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return (acc + (64'd1 << 31)) >> 32;
    endfunction

    // q30 by q30 product, rounded half up
    function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = (2*MW)'(a) * (2*MW)'(b) + (2*MW)'(64'sd536870912);
        return p[MW+29:30];
    endfunction

endpackage

/* hw/rtl/gcd_to_rad.sv */
// gcd_to_rad: three-stage pipelined conversion of 1e-7 degree units to q30 radians
// uses gcd_pkg; division by the constant is a reciprocal multiply and correction
module gcd_to_rad
    import gcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [31:0]   i_deg,
    output logic                 o_vld,
    output logic signed [MW-1:0] o_rad
);

    localparam logic [63:0] DEN      = 64'd1800000000;
    localparam logic [63:0] PI_U     = 64'd3373259426;
    localparam logic [95:0] K_WIDE   = (96'd3373259426 << 32) / 96'd1800000000;
    localparam logic [32:0] K_RECIP  = K_WIDE[32:0];
    localparam logic [33:0] DEN1     = 34'd1800000000;
    localparam logic [33:0] DEN2     = 34'd3600000000;

    logic [30:0] mag;
    logic [63:0] n_est;

    logic        r1_vld, r2_vld, r3_vld;
    logic [63:0] r1_num;
    logic [32:0] r1_est;
    logic        r1_neg;
    logic [32:0] r2_q0;
    logic [33:0] r2_rem;
    logic        r2_neg;
    logic signed [MW-1:0] r3_rad;
    logic [32:0] q;

    assign mag   = i_deg[31] ? 31'(-i_deg) : i_deg[30:0];
    assign n_est = (64'(mag) * 64'(K_RECIP)) >> 32;
    assign q     = r2_q0 + 33'(r2_rem >= DEN1) + 33'(r2_rem >= DEN2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_num <= 64'(mag) * PI_U + 64'd900000000;
            r1_est <= n_est[32:0];
            r1_neg <= i_deg[31];
            r2_q0  <= r1_est;
            r2_rem <= 34'(r1_num - 64'(r1_est) * DEN);
            r2_neg <= r1_neg;
            r3_rad <= r2_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    end

    assign o_vld = r3_vld;
    assign o_rad = r3_rad;

endmodule

/* hw/rtl/gcd_cordic.sv */
// gcd_cordic: unrolled cordic, one register stage per iteration, rotation or vectoring
// uses gcd_pkg for the datapath width and the arctangent table
module gcd_cordic
    import gcd_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter bit VECT  = 1'b0,
    parameter int SW    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    input  logic [SW-1:0]        i_sb,
    output logic                 o_vld,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_z,
    output logic [SW-1:0]        o_sb
);

    logic signed [CW-1:0] r_x  [STEPS];
    logic signed [CW-1:0] r_y  [STEPS];
    logic signed [CW-1:0] r_z  [STEPS];
    logic [SW-1:0]        r_sb [STEPS];
    logic [STEPS-1:0]     r_vld;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_step
            localparam logic [63:0] T_WIDE = atan_q30(g);
            localparam logic signed [CW-1:0] T = $signed(T_WIDE[CW-1:0]);
            logic signed [CW-1:0] px, py, pz, xs, ys;
            logic [SW-1:0]        psb;
            logic                 pv, pos;
            if (g == 0) begin : g_first
                assign px  = i_x;
                assign py  = i_y;
                assign pz  = i_z;
                assign psb = i_sb;
                assign pv  = i_vld;
            end else begin : g_next
                assign px  = r_x[g-1];
                assign py  = r_y[g-1];
                assign pz  = r_z[g-1];
                assign psb = r_sb[g-1];
                assign pv  = r_vld[g-1];
            end
            assign xs  = px >>> g;
            assign ys  = py >>> g;
            // rotation steers on the residual angle, vectoring on the sign of y
            assign pos = VECT ? (py >= 0) : (pz >= 0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= pv;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sb[g] <= psb;
                    if (VECT) begin
                        r_x[g] <= pos ? px + ys : px - ys;
                        r_y[g] <= pos ? py - xs : py + xs;
                        r_z[g] <= pos ? pz + T : pz - T;
                    end else begin
                        r_x[g] <= pos ? px - ys : px + ys;
                        r_y[g] <= pos ? py + xs : py - xs;
                        r_z[g] <= pos ? pz - T : pz + T;
                    end
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[STEPS-1];
    assign o_x   = r_x[STEPS-1];
    assign o_y   = r_y[STEPS-1];
    assign o_z   = r_z[STEPS-1];
    assign o_sb  = r_sb[STEPS-1];

endmodule

/* hw/rtl/great_circle_distance_unit.sv */
// great_circle_distance_unit: top level, spherical distance by the atan2 form
// uses gcd_pkg, gcd_to_rad and gcd_cordic
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_from_latitude, i_from_longitude,
//                                           i_to_latitude, i_to_longitude
//  output   out        o_valid / i_stall    o_distance_mm
//
// one transaction enters per cycle while o_stall is low; the path runs through the
// three cordic pipelines in series (rotation, magnitude, atan2)
// reset (i_rst_n low, synchronous) clears every stage valid bit, no data is kept
// the whole pipeline advances together; it freezes only when the output register
// holds a transaction and i_stall is high, and o_stall then holds off the input
module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_from_latitude,
    input  logic signed [31:0] i_from_longitude,
    input  logic signed [30:0] i_to_latitude,
    input  logic signed [31:0] i_to_longitude,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [34:0]        o_distance_mm
);

    // global advance: everything shifts unless the output is held
    logic en;
    logic r_out_vld;
    logic [34:0] r_out_mm;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // ---- stage 0: latitude clamp and longitude difference wrap ----
    logic signed [30:0] n_lat1, n_lat2;
    logic signed [33:0] dl_raw, dl_wrap;
    logic               r0_vld;
    logic signed [31:0] r0_lat1, r0_lat2, r0_dl;

    always_comb begin
        if (i_from_latitude > LAT_LIMIT) begin
            n_lat1 = LAT_LIMIT;
        end else if (i_from_latitude < -LAT_LIMIT) begin
            n_lat1 = -LAT_LIMIT;
        end else begin
            n_lat1 = i_from_latitude;
        end
        if (i_to_latitude > LAT_LIMIT) begin
            n_lat2 = LAT_LIMIT;
        end else if (i_to_latitude < -LAT_LIMIT) begin
            n_lat2 = -LAT_LIMIT;
        end else begin
            n_lat2 = i_to_latitude;
        end
        dl_raw = 34'(i_to_longitude) - 34'(i_from_longitude);
        // one wrap brings any 32-bit difference into [-180, 180) degrees
        if (dl_raw >= DLON_HALF) begin
            dl_wrap = dl_raw - DLON_FULL;
        end else if (dl_raw < -DLON_HALF) begin
            dl_wrap = dl_raw + DLON_FULL;
        end else begin
            dl_wrap = dl_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_lat1 <= 32'(n_lat1);
            r0_lat2 <= 32'(n_lat2);
            r0_dl   <= dl_wrap[31:0];
        end
    end

    // ---- stages 1-3: degree units to q30 radians ----
    logic                 rad_vld;
    logic signed [MW-1:0] rad_dl, rad_l1, rad_l2;

    gcd_to_rad u_rad_dl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r0_vld),
        .i_deg(r0_dl), .o_vld(rad_vld), .o_rad(rad_dl)
    );
    gcd_to_rad u_rad_l1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r0_vld),
        .i_deg(r0_lat1), .o_vld(), .o_rad(rad_l1)
    );
    gcd_to_rad u_rad_l2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r0_vld),
        .i_deg(r0_lat2), .o_vld(), .o_rad(rad_l2)
    );

    // ---- stage 4: fold the longitude angle into +-pi/2 ----
    logic                 r1_vld, r1_flip;
    logic signed [MW-1:0] r1_a, r1_l1, r1_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= rad_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_l1 <= rad_l1;
            r1_l2 <= rad_l2;
            if (rad_dl > HALF_PI_Q30) begin
                r1_a    <= rad_dl - PI_Q30;
                r1_flip <= 1'b1;
            end else if (rad_dl < -HALF_PI_Q30) begin
                r1_a    <= rad_dl + PI_Q30;
                r1_flip <= 1'b1;
            end else begin
                r1_a    <= rad_dl;
                r1_flip <= 1'b0;
            end
        end
    end

    // ---- rotation cordics: sine and cosine of the three angles ----
    logic                 rot_vld, rot_flip;
    logic signed [CW-1:0] c_dl, s_dl, c_l1, s_l1, c_l2, s_l2;

    gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0), .SW(1)) u_rot_dl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r1_vld),
        .i_x(CW'(GAIN_Q30)), .i_y('0), .i_z(CW'(r1_a)), .i_sb(r1_flip),
        .o_vld(rot_vld), .o_x(c_dl), .o_y(s_dl), .o_z(), .o_sb(rot_flip)
    );
    gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0), .SW(1)) u_rot_l1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r1_vld),
        .i_x(CW'(GAIN_Q30)), .i_y('0), .i_z(CW'(r1_l1)), .i_sb(1'b0),
        .o_vld(), .o_x(c_l1), .o_y(s_l1), .o_z(), .o_sb()
    );
    gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0), .SW(1)) u_rot_l2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r1_vld),
        .i_x(CW'(GAIN_Q30)), .i_y('0), .i_z(CW'(r1_l2)), .i_sb(1'b0),
        .o_vld(), .o_x(c_l2), .o_y(s_l2), .o_z(), .o_sb()
    );

    // ---- stage: undo the fold by pi, narrow to q30 operands ----
    logic                 r2_vld;
    logic signed [MW-1:0] r2_sd, r2_cd, r2_sl1, r2_cl1, r2_sl2, r2_cl2;

    // ---- product stages ----
    logic                 r3_vld, r4_vld, r5_vld;
    logic signed [MW-1:0] r3_p1, r3_p2, r3_e, r3_p4, r3_p5, r3_cd;
    logic signed [MW-1:0] r4_p1, r4_p2c, r4_e, r4_p4, r4_p5c;
    logic signed [MW-1:0] r5_absd, r5_e, r5_dot;
    logic signed [MW-1:0] d_term;

    assign d_term = r4_p1 - r4_p2c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= rot_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sd  <= rot_flip ? -s_dl[MW-1:0] : s_dl[MW-1:0];
            r2_cd  <= rot_flip ? -c_dl[MW-1:0] : c_dl[MW-1:0];
            r2_sl1 <= s_l1[MW-1:0];
            r2_cl1 <= c_l1[MW-1:0];
            r2_sl2 <= s_l2[MW-1:0];
            r2_cl2 <= c_l2[MW-1:0];

            r3_p1 <= mulq(r2_cl1, r2_sl2);
            r3_p2 <= mulq(r2_sl1, r2_cl2);
            r3_e  <= mulq(r2_cl2, r2_sd);
            r3_p4 <= mulq(r2_sl1, r2_sl2);
            r3_p5 <= mulq(r2_cl1, r2_cl2);
            r3_cd <= r2_cd;

            r4_p1  <= r3_p1;
            r4_p2c <= mulq(r3_p2, r3_cd);
            r4_e   <= r3_e;
            r4_p4  <= r3_p4;
            r4_p5c <= mulq(r3_p5, r3_cd);

            // cross term components and the dot term
            r5_absd <= (d_term < 0) ? -d_term : d_term;
            r5_e    <= r4_e;
            r5_dot  <= r4_p4 + r4_p5c;
        end
    end

    // ---- vectoring cordic: magnitude of the cross term ----
    logic                 v1_vld;
    logic signed [CW-1:0] v1_x;
    logic [MW-1:0]        v1_dot;

    gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b1), .SW(MW)) u_vec_mag (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r5_vld),
        .i_x(CW'(r5_absd)), .i_y(CW'(r5_e)), .i_z('0), .i_sb(r5_dot),
        .o_vld(v1_vld), .o_x(v1_x), .o_y(), .o_z(), .o_sb(v1_dot)
    );

    // ---- gain correction, then atan2 operand select ----
    logic                 r6_vld, r7_vld;
    logic signed [MW-1:0] r6_mag, r6_dot;
    logic signed [MW-1:0] r7_vx, r7_vy;
    logic                 r7_base, r7_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= v1_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mag <= mulq(v1_x[MW-1:0], GAIN_Q30);
            r6_dot <= $signed(v1_dot);
            // negative dot: turn the vector by -90 degrees and add pi/2 later
            // the turned vector has a nonzero y, so it is never the zero vector
            if (r6_dot < 0) begin
                r7_vx   <= r6_mag;
                r7_vy   <= -r6_dot;
                r7_base <= 1'b1;
                r7_zero <= 1'b0;
            end else begin
                r7_vx   <= r6_dot;
                r7_vy   <= r6_mag;
                r7_base <= 1'b0;
                r7_zero <= (r6_dot == 0) && (r6_mag == 0);
            end
        end
    end

    // ---- vectoring cordic: central angle ----
    logic                 v2_vld;
    logic signed [CW-1:0] v2_z;
    logic [1:0]           v2_sb;

    gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b1), .SW(2)) u_vec_ang (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r7_vld),
        .i_x(CW'(r7_vx)), .i_y(CW'(r7_vy)), .i_z('0), .i_sb({r7_base, r7_zero}),
        .o_vld(v2_vld), .o_x(), .o_y(), .o_z(v2_z), .o_sb(v2_sb)
    );

    // ---- angle, scale by radius, round to millimetres ----
    logic                 r8_vld, r9_vld;
    logic signed [MW-1:0] ang;
    logic [32:0]          r8_ang;
    logic [55:0]          r9_p;
    logic [35:0]          mm_hi;
    logic [39:0]          mm_lo;
    logic [36:0]          mm_sum;

    always_comb begin
        if (v2_sb[0]) begin
            ang = '0;
        end else if (v2_sb[1]) begin
            ang = HALF_PI_Q30 + v2_z[MW-1:0];
        end else begin
            ang = v2_z[MW-1:0];
        end
        mm_hi  = 36'(r9_p[55:30]) * 36'd1000;
        mm_lo  = (40'(r9_p[29:0]) * 40'd1000 + 40'd536870912) >> 30;
        mm_sum = 37'(mm_hi) + 37'(mm_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r8_vld    <= v2_vld;
            r9_vld    <= r8_vld;
            r_out_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // rounding can leave a small negative angle
            r8_ang   <= (ang < 0) ? '0 : ang[32:0];
            r9_p     <= 56'(r8_ang) * 56'(RADIUS_M);
            r_out_mm <= (mm_sum > MAX_MM) ? MAX_MM[34:0] : mm_sum[34:0];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_distance_mm = r_out_mm;

endmodule
